[hw/rtl/rebd_pkg.sv]
`default_nettype none

package rebd_pkg;

    localparam int TIME_BITS = 32;
    localparam int CNT_BITS = 16;
    localparam int IN_DATA_BITS = 8;
    localparam int OUT_DATA_BITS = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int MAX_OUT = 3;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLICK_MAX = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DBL_MAX = 2'd3;

    localparam logic [CNT_BITS-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CNT_BITS-1:0] HOLD_RST = 16'd1000;
    localparam logic [CNT_BITS-1:0] CLICK_MAX_RST = 16'd300;
    localparam logic [CNT_BITS-1:0] DBL_MAX_RST = 16'd800;

    typedef enum logic [2:0] {
        EV_CW = 3'd0,
        EV_CCW = 3'd1,
        EV_DOWN = 3'd2,
        EV_UP = 3'd3,
        EV_CLICK = 3'd4,
        EV_DOUBLE = 3'd5,
        EV_TRIPLE = 3'd6,
        EV_HOLD = 3'd7
    } evt_code_t;

    // inputs of the button table machine
    typedef enum logic [2:0] {
        BE_DOWN = 3'd0,
        BE_UP = 3'd1,
        BE_CLICK = 3'd2,
        BE_DBL = 3'd3,
        BE_TICK = 3'd4
    } btn_ev_t;

    typedef struct packed {
        logic      vld;
        evt_code_t code;
    } evt_t;

    typedef struct packed {
        evt_t hold;
        evt_t deb;
        evt_t btn;
    } btn_evts_t;

    typedef struct packed {
        logic [CNT_BITS-1:0] debounce_ticks;
        logic [CNT_BITS-1:0] hold_ticks;
        logic [CNT_BITS-1:0] click_max_ticks;
        logic [CNT_BITS-1:0] double_click_max_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0]              cnt;
        evt_code_t [MAX_OUT-1:0] codes;
    } grp_t;

    // quadrature next state, index [state][{clk, dt}]
    localparam logic [2:0] ENC_NEXT [8][4] = '{
        '{3'd7, 3'd1, 3'd4, 3'd0},
        '{3'd2, 3'd1, 3'd3, 3'd0},
        '{3'd2, 3'd1, 3'd3, 3'd7},
        '{3'd2, 3'd7, 3'd3, 3'd0},
        '{3'd5, 3'd6, 3'd4, 3'd0},
        '{3'd5, 3'd6, 3'd4, 3'd7},
        '{3'd5, 3'd6, 3'd7, 3'd0},
        '{3'd7, 3'd7, 3'd7, 3'd0}
    };

    // button output, bit 3 set means no event, index [state][event]
    localparam logic [3:0] BTN_OUT [8][5] = '{
        '{4'd8, 4'd8, 4'd4, 4'd5, 4'd8},
        '{4'd8, 4'd8, 4'd4, 4'd5, 4'd7},
        '{4'd8, 4'd8, 4'd4, 4'd5, 4'd4},
        '{4'd8, 4'd8, 4'd5, 4'd5, 4'd5},
        '{4'd8, 4'd8, 4'd6, 4'd6, 4'd6},
        '{4'd8, 4'd8, 4'd8, 4'd8, 4'd7},
        '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8}
    };

    localparam logic [2:0] BTN_NEXT [8][5] = '{
        '{3'd1, 3'd0, 3'd2, 3'd3, 3'd0},
        '{3'd1, 3'd0, 3'd2, 3'd3, 3'd5},
        '{3'd1, 3'd0, 3'd2, 3'd3, 3'd6},
        '{3'd1, 3'd3, 3'd3, 3'd4, 3'd5},
        '{3'd1, 3'd0, 3'd4, 3'd4, 3'd5},
        '{3'd1, 3'd0, 3'd2, 3'd3, 3'd5},
        '{3'd1, 3'd0, 3'd2, 3'd3, 3'd6},
        '{3'd1, 3'd0, 3'd2, 3'd3, 3'd6}
    };

    function automatic logic [CNT_BITS-1:0] at_least_one(input logic [CNT_BITS-1:0] v);
        return (v == '0) ? CNT_BITS'(1) : v;
    endfunction

    function automatic evt_t btn_out(input logic [2:0] s, input btn_ev_t ev);
        logic [3:0] raw;
        evt_t       r;
        raw = BTN_OUT[s][ev];
        r.vld = ~raw[3];
        r.code = evt_code_t'(raw[2:0]);
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rotary_encoder_button_event_decoder_core.sv]
`default_nettype none

// Rotary encoder and push-button event decoder. Each transfer on s_* is one
// sampled tick of the CLK, DT and switch pins and yields zero to three events
// on m_*, with m_tlast on the last event of that tick. A tick is registered on
// input, decoded combinationally and its events are handed out one per cycle
// unless m_tready stalls, so ticks yielding at most one event sustain one tick
// per cycle; a tick with more events stalls the next eventful tick till its last
// is taken. The configuration channel is always ready, one register write per cycle.
module rotary_encoder_button_event_decoder_core (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire  [rebd_pkg::IN_DATA_BITS-1:0]     s_tdata,  // [0] clk_level, [1] dt_level,
                                                            // [2] sw_level, rest zero
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [rebd_pkg::OUT_DATA_BITS-1:0]    m_tdata,  // [2:0] event_code, rest zero
    output logic                                  m_tlast,  // last_of_tick
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [rebd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire  [rebd_pkg::CNT_BITS-1:0]         cfg_data
);
    import rebd_pkg::*;

    logic      in_vld_reg;
    logic      in_clk_reg;
    logic      in_dt_reg;
    logic      in_sw_reg;
    cfg_t      cfg_reg;
    logic      adv;
    logic      can_load;
    evt_t      enc_evt;
    btn_evts_t btn_evts;
    evt_t      cand [4];
    grp_t      grp;
    logic [2:0] n;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= DEBOUNCE_RST;
            cfg_reg.hold_ticks <= HOLD_RST;
            cfg_reg.click_max_ticks <= CLICK_MAX_RST;
            cfg_reg.double_click_max_ticks <= DBL_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:  cfg_reg.debounce_ticks <= cfg_data;
                REG_HOLD:      cfg_reg.hold_ticks <= cfg_data;
                REG_CLICK_MAX: cfg_reg.click_max_ticks <= cfg_data;
                REG_DBL_MAX:   cfg_reg.double_click_max_ticks <= cfg_data;
                default:       ;
            endcase
        end
    end

    // gather events in tick order, keeping the first three
    always_comb
    begin
        cand[0] = enc_evt;
        cand[1] = btn_evts.hold;
        cand[2] = btn_evts.deb;
        cand[3] = btn_evts.btn;
        grp = '0;
        n = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand[i].vld && (n < 3'(MAX_OUT)))
            begin
                grp.codes[n[1:0]] = cand[i].code;
                n = n + 3'd1;
            end
        end
        grp.cnt = n[1:0];
        adv = in_vld_reg && ((n == 3'd0) || can_load);
        s_tready = !in_vld_reg || adv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_clk_reg <= s_tdata[0];
            in_dt_reg <= s_tdata[1];
            in_sw_reg <= s_tdata[2];
        end
    end

    rebd_quad u_quad (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .clk_level (in_clk_reg),
        .dt_level  (in_dt_reg),
        .enc_evt   (enc_evt)
    );

    rebd_button u_button (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .sw_level (in_sw_reg),
        .cfg      (cfg_reg),
        .evts     (btn_evts)
    );

    rebd_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (adv && (n != 3'd0)),
        .grp      (grp),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[hw/rtl/rebd_quad.sv]
`default_nettype none

module rebd_quad (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            adv,
    input  wire            clk_level,
    input  wire            dt_level,
    output rebd_pkg::evt_t enc_evt
);
    import rebd_pkg::*;

    logic [2:0] enc_state_reg;
    logic [2:0] enc_state_next;

    always_comb
    begin
        enc_evt.vld = 1'b0;
        enc_evt.code = EV_CW;
        // a detent completes when both lines return high
        if (clk_level && dt_level)
        begin
            if (enc_state_reg == 3'd3)
            begin
                enc_evt.vld = 1'b1;
                enc_evt.code = EV_CW;
            end
            else if (enc_state_reg == 3'd6)
            begin
                enc_evt.vld = 1'b1;
                enc_evt.code = EV_CCW;
            end
        end
        enc_state_next = ENC_NEXT[enc_state_reg][{clk_level, dt_level}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_state_reg <= 3'd0;
        end
        else if (adv)
        begin
            enc_state_reg <= enc_state_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rebd_button.sv]
`default_nettype none

module rebd_button (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 adv,
    input  wire                 sw_level,
    input  rebd_pkg::cfg_t      cfg,
    output rebd_pkg::btn_evts_t evts
);
    import rebd_pkg::*;

    logic [2:0]           btn_state_reg, btn_state_next;
    logic                 prev_sw_reg, prev_sw_next;
    logic [TIME_BITS-1:0] tick_time_reg;
    logic [TIME_BITS-1:0] press_time_reg, press_time_next;
    logic [TIME_BITS-1:0] release_time_reg, release_time_next;
    logic [TIME_BITS-1:0] last_press_reg, last_press_next;
    logic [CNT_BITS-1:0]  deb_left_reg, deb_left_next;
    logic                 deb_run_reg, deb_run_next;
    logic [CNT_BITS-1:0]  hold_left_reg, hold_left_next;
    logic                 hold_run_reg, hold_run_next;

    logic [2:0]           mid_state;
    logic [TIME_BITS-1:0] rel_delta;
    logic [TIME_BITS-1:0] press_delta;
    logic                 is_click;
    logic                 is_dbl;
    btn_ev_t              bev;

    always_comb
    begin
        rel_delta = release_time_reg - last_press_reg;
        press_delta = press_time_reg - last_press_reg;
        is_click = rel_delta < TIME_BITS'(cfg.click_max_ticks);
        is_dbl = press_delta < TIME_BITS'(cfg.double_click_max_ticks);

        btn_state_next = btn_state_reg;
        prev_sw_next = prev_sw_reg;
        press_time_next = press_time_reg;
        release_time_next = release_time_reg;
        last_press_next = last_press_reg;
        deb_left_next = deb_left_reg;
        deb_run_next = deb_run_reg;
        hold_left_next = hold_left_reg;
        hold_run_next = hold_run_reg;
        evts = '0;
        bev = BE_DOWN;

        // periodic hold timer
        mid_state = btn_state_reg;
        if (hold_run_reg)
        begin
            if (hold_left_reg > CNT_BITS'(1))
            begin
                hold_left_next = hold_left_reg - CNT_BITS'(1);
            end
            else
            begin
                hold_left_next = at_least_one(cfg.hold_ticks);
                evts.hold = btn_out(btn_state_reg, BE_TICK);
                mid_state = BTN_NEXT[btn_state_reg][BE_TICK];
            end
        end
        btn_state_next = mid_state;

        // an edge restarts debounce, so no expiry in the same tick
        if (sw_level != prev_sw_reg)
        begin
            if (sw_level)
            begin
                release_time_next = tick_time_reg;
            end
            else
            begin
                press_time_next = tick_time_reg;
            end
            prev_sw_next = sw_level;
            deb_left_next = at_least_one(cfg.debounce_ticks);
            deb_run_next = 1'b1;
        end
        else if (deb_run_reg)
        begin
            if (deb_left_reg > CNT_BITS'(1))
            begin
                deb_left_next = deb_left_reg - CNT_BITS'(1);
            end
            else
            begin
                deb_left_next = '0;
                deb_run_next = 1'b0;
                evts.deb.vld = 1'b1;
                if (sw_level)
                begin
                    bev = is_click ? BE_CLICK : BE_UP;
                    evts.deb.code = EV_UP;
                    hold_run_next = 1'b0;
                    hold_left_next = '0;
                end
                else
                begin
                    bev = is_dbl ? BE_DBL : BE_DOWN;
                    evts.deb.code = EV_DOWN;
                    last_press_next = press_time_reg;
                    hold_run_next = 1'b1;
                    hold_left_next = at_least_one(cfg.hold_ticks);
                end
                evts.btn = btn_out(mid_state, bev);
                btn_state_next = BTN_NEXT[mid_state][bev];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            btn_state_reg <= 3'd0;
            prev_sw_reg <= 1'b1;
            tick_time_reg <= '0;
            press_time_reg <= '0;
            release_time_reg <= '0;
            last_press_reg <= '0;
            deb_left_reg <= '0;
            deb_run_reg <= 1'b0;
            hold_left_reg <= '0;
            hold_run_reg <= 1'b0;
        end
        else if (adv)
        begin
            btn_state_reg <= btn_state_next;
            prev_sw_reg <= prev_sw_next;
            tick_time_reg <= tick_time_reg + TIME_BITS'(1);
            press_time_reg <= press_time_next;
            release_time_reg <= release_time_next;
            last_press_reg <= last_press_next;
            deb_left_reg <= deb_left_next;
            deb_run_reg <= deb_run_next;
            hold_left_reg <= hold_left_next;
            hold_run_reg <= hold_run_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rebd_outq.sv]
`default_nettype none

module rebd_outq (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                load,
    input  rebd_pkg::grp_t                     grp,
    output logic                               can_load,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [rebd_pkg::OUT_DATA_BITS-1:0] m_tdata,  // [2:0] event_code, rest zero
    output logic                               m_tlast   // last_of_tick
);
    import rebd_pkg::*;

    logic                    vld_reg;
    logic [1:0]              cnt_reg;
    logic [1:0]              idx_reg;
    evt_code_t [MAX_OUT-1:0] codes_reg;
    logic                    is_last;
    logic                    pop;

    always_comb
    begin
        is_last = (idx_reg == 2'(cnt_reg - 2'd1));
        pop = vld_reg && m_tready;
        can_load = !vld_reg || (pop && is_last);
        m_tvalid = vld_reg;
        m_tdata = OUT_DATA_BITS'(codes_reg[idx_reg]);
        m_tlast = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= 2'd0;
        end
        else if (load && can_load)
        begin
            vld_reg <= 1'b1;
            idx_reg <= 2'd0;
        end
        else if (pop)
        begin
            if (is_last)
            begin
                vld_reg <= 1'b0;
                idx_reg <= 2'd0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // group payload
    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            cnt_reg <= grp.cnt;
            codes_reg <= grp.codes;
        end
    end

endmodule

`default_nettype wire
